[sv/pcbs_pkg.sv]
// ----------------------------------------------------------------------------
// pcbs_pkg: shared types and constants for per-class box suppression
// Holds the item structs, register codes and the default configuration.
// ----------------------------------------------------------------------------
package pcbs_pkg;

    localparam int DEF_MAX_BOXES = 64;
    localparam logic [15:0] IOU_THR_RESET = 16'd13107;
    localparam logic [0:0] REG_IOU_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [15:0] left_edge;
        logic [15:0] top_edge;
        logic [15:0] right_edge;
        logic [15:0] bottom_edge;
        logic [15:0] confidence;
        logic [7:0]  class_id;
        logic        last_box;
    } box_in_t;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_top;
        logic [15:0] out_right;
        logic [15:0] out_bottom;
        logic [15:0] out_score;
        logic [7:0]  out_class;
        logic        last_kept;
        logic        overflowed;
    } box_out_t;

    // one stored box entry
    typedef struct packed {
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] r;
        logic [15:0] b;
        logic [15:0] s;
        logic [7:0]  c;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // overlap unit handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
        logic hit;
    } iou_ctl_t;

endpackage

[sv/pcbs_ram.sv]
// ----------------------------------------------------------------------------
// pcbs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/pcbs_iou.sv]
// ----------------------------------------------------------------------------
// pcbs_iou: multi-cycle overlap test
// One shared 18x18 signed multiplier walks through the products in turn.
// ----------------------------------------------------------------------------
module pcbs_iou
    import pcbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  entry_t      a,
    input  entry_t      b,
    input  logic [15:0] thr,
    output iou_ctl_t    ctl
);
    localparam logic [2:0] S_IDLE = 3'd0, S_AA = 3'd1, S_AB = 3'd2, S_IN = 3'd3,
                           S_UN = 3'd4, S_TL = 3'd5, S_TH = 3'd6, S_DONE = 3'd7;

    logic [2:0] st_reg, st_next;
    logic signed [17:0] ma, mb;
    logic signed [35:0] prod;
    logic signed [35:0] area_a_reg, area_b_reg, inter_reg;
    logic signed [37:0] uni_reg;
    logic [49:0] rhs_reg;
    logic [15:0] iw, ih;
    logic [15:0] mr, ml, mb2, mt;

    // clamped intersection sides
    always_comb
    begin
        mr  = (a.r < b.r) ? a.r : b.r;
        ml  = (a.l > b.l) ? a.l : b.l;
        mb2 = (a.b < b.b) ? a.b : b.b;
        mt  = (a.t > b.t) ? a.t : b.t;
        iw  = (mr > ml) ? (mr - ml) : 16'd0;
        ih  = (mb2 > mt) ? (mb2 - mt) : 16'd0;
    end

    // positive union is below 2^33: threshold product in a low and a high half
    always_comb
    begin
        case (st_reg)
            S_AA:
            begin
                ma = 18'(signed'({2'b0, a.r}) - signed'({2'b0, a.l}));
                mb = 18'(signed'({2'b0, a.b}) - signed'({2'b0, a.t}));
            end
            S_AB:
            begin
                ma = 18'(signed'({2'b0, b.r}) - signed'({2'b0, b.l}));
                mb = 18'(signed'({2'b0, b.b}) - signed'({2'b0, b.t}));
            end
            S_TL:
            begin
                ma = signed'({2'b0, thr});
                mb = signed'({1'b0, uni_reg[16:0]});
            end
            S_TH:
            begin
                ma = signed'({2'b0, thr});
                mb = signed'({2'b0, uni_reg[32:17]});
            end
            default:
            begin
                ma = signed'({2'b0, iw});
                mb = signed'({2'b0, ih});
            end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (start) st_next = S_AA;
            S_AA:   st_next = S_AB;
            S_AB:   st_next = S_IN;
            S_IN:   st_next = S_UN;
            S_UN:   st_next = S_TL;
            S_TL:   st_next = S_TH;
            S_TH:   st_next = S_DONE;
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_AA: area_a_reg <= prod;
            S_AB: area_b_reg <= prod;
            S_IN: inter_reg  <= prod;
            S_UN: uni_reg    <= 38'(area_a_reg) + 38'(area_b_reg) - 38'(inter_reg);
            S_TL: rhs_reg    <= {14'b0, prod};
            S_TH: rhs_reg    <= rhs_reg + {prod[32:0], 17'b0};
            default: ;
        endcase
    end

    assign ctl.start = start;
    assign ctl.busy  = (st_reg != S_IDLE);
    assign ctl.done  = (st_reg == S_DONE);
    assign ctl.hit   = (uni_reg > 38'sd0) && ({2'b0, inter_reg[31:0], 16'b0} > rhs_reg);
endmodule

[sv/per_class_box_suppression.sv]
// ----------------------------------------------------------------------------
// per_class_box_suppression: greedy per-class non-maximum suppression
// Loads boxes into RAM, then emits the kept boxes class by class.
// ----------------------------------------------------------------------------
// Boxes are taken one per cycle while loading; a box arriving when MAX_BOXES
// are stored is dropped and the set is flagged. The item marked last_box
// starts suppression and the input stalls until the final kept box has been
// placed in the output register. Classes run in order of first appearance.
// For each class a scan from the class's first box to the end of the stored
// set (one RAM read port) finds the best live box, which is emitted; a
// second scan runs each live box of the class through the shared overlap
// unit, with its single multiplier, and the two scans repeat until no live
// box of the class is left. Each kept box is held back one step so that the
// final one can be marked last_kept.
// ----------------------------------------------------------------------------
module per_class_box_suppression
    import pcbs_pkg::*;
#(
    parameter int MAX_BOXES = DEF_MAX_BOXES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  box_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output box_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = AW + 1;

    localparam logic [3:0] S_LOAD = 4'd0, S_CLS_RD = 4'd1, S_CLS_CK = 4'd2,
                           S_BEST_RD = 4'd3, S_BEST_CK = 4'd4, S_EMIT_RD = 4'd5,
                           S_EMIT = 4'd6, S_SUP_RD = 4'd7, S_SUP_CK = 4'd8,
                           S_SUP_WT = 4'd9, S_NEXT_CLS = 4'd10, S_DONE = 4'd11;

    logic [3:0] st_reg, st_next;
    logic [15:0] thr_reg;
    logic [CW-1:0] count_reg;
    logic ovf_reg;
    logic [MAX_BOXES-1:0] live_reg;   // not yet emitted or suppressed
    logic [MAX_BOXES-1:0] done_cls_reg; // box's class already handled
    logic [AW-1:0] idx_reg;   // scan pointer
    logic [AW-1:0] cls_idx_reg; // first box of the current class
    logic [7:0] cls_reg;
    logic found_reg;
    logic [AW-1:0] best_reg;
    logic [15:0] best_s_reg;
    entry_t best_e_reg;
    box_out_t out_reg;
    logic out_v_reg;
    logic pend_reg;     // a kept box awaits the next one to learn last_kept
    box_out_t pend_e_reg; // that held-back kept box
    box_out_t final_out;

    // RAM
    logic ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    entry_t ram_wd, ram_rd;

    pcbs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BOXES)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    iou_ctl_t iou;
    logic iou_start;
    pcbs_iou u_iou (
        .clk(clk), .rst_n(rst_n), .start(iou_start), .a(best_e_reg),
        .b(ram_rd), .thr(thr_reg), .ctl(iou)
    );

    logic in_acc;
    logic out_free;
    logic out_load;
    logic last_idx;
    assign in_stall = (st_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_v_reg || !out_stall;
    assign out_load = out_free && ((st_reg == S_EMIT && pend_reg) || st_reg == S_DONE);
    assign last_idx = ({1'b0, idx_reg} == count_reg - CW'(1));

    assign ram_we = in_acc && (count_reg < CW'(MAX_BOXES));
    assign ram_wa = count_reg[AW-1:0];
    assign ram_wd = '{l: in_data.left_edge, t: in_data.top_edge,
                      r: in_data.right_edge, b: in_data.bottom_edge,
                      s: in_data.confidence, c: in_data.class_id};
    // hold the best box's address while it waits for the output
    assign ram_ra = (st_reg == S_EMIT_RD || st_reg == S_EMIT) ? best_reg : idx_reg;
    assign iou_start = (st_reg == S_SUP_CK) && (ram_rd.c == cls_reg) && live_reg[idx_reg];

    // final kept box of the set
    always_comb
    begin
        final_out = pend_e_reg;
        final_out.last_kept = 1'b1;
    end

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {REG_IOU_THRESHOLD, 1'b0}) ? {16'b0, thr_reg} : 32'b0;

    // mask of stored boxes
    logic [MAX_BOXES-1:0] used_mask;
    always_comb
    begin
        for (int k = 0; k < MAX_BOXES; k++)
        begin
            used_mask[k] = (k < int'(count_reg));
        end
    end
    logic all_done;
    assign all_done = ((done_cls_reg | ~used_mask) == '1);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_LOAD:     if (in_acc && in_data.last_box) st_next = S_CLS_RD;
            S_CLS_RD:   st_next = S_CLS_CK;
            S_CLS_CK:   st_next = done_cls_reg[idx_reg] ? S_CLS_RD : S_BEST_RD;
            S_BEST_RD:  st_next = S_BEST_CK;
            S_BEST_CK:  st_next = last_idx ? (found_reg || ((ram_rd.c == cls_reg)
                                   && live_reg[idx_reg]) ? S_EMIT_RD : S_NEXT_CLS)
                                 : S_BEST_RD;
            S_EMIT_RD:  st_next = S_EMIT;
            S_EMIT:     if (out_free) st_next = S_SUP_RD;
            S_SUP_RD:   st_next = S_SUP_CK;
            S_SUP_CK:   st_next = iou_start ? S_SUP_WT
                                 : (last_idx ? S_BEST_RD : S_SUP_RD);
            S_SUP_WT:   if (iou.done) st_next = last_idx ? S_BEST_RD : S_SUP_RD;
            S_NEXT_CLS: st_next = all_done ? S_DONE : S_CLS_RD;
            S_DONE:     if (out_free) st_next = S_LOAD;
            default:    st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_LOAD;
            thr_reg   <= IOU_THR_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            live_reg  <= '0;
            done_cls_reg <= '0;
            out_v_reg <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == {REG_IOU_THRESHOLD, 1'b0})
            begin
                thr_reg <= pwdata[15:0];
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
            case (st_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (ram_we)
                        begin
                            count_reg <= count_reg + CW'(1);
                            live_reg[count_reg[AW-1:0]] <= 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        done_cls_reg <= '0;
                        idx_reg <= '0;
                        pend_reg <= 1'b0;
                    end
                    st_reg <= st_next;
                end
                S_CLS_RD:
                begin
                    st_reg <= st_next;
                end
                S_CLS_CK:
                begin
                    if (done_cls_reg[idx_reg])
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                    else
                    begin
                        cls_reg <= ram_rd.c;
                        cls_idx_reg <= idx_reg;
                        found_reg <= 1'b0;
                    end
                    st_reg <= st_next;
                end
                S_BEST_RD:
                begin
                    st_reg <= st_next;
                end
                S_BEST_CK:
                begin
                    if (ram_rd.c == cls_reg)
                    begin
                        done_cls_reg[idx_reg] <= 1'b1;
                        if (live_reg[idx_reg] && (!found_reg || ram_rd.s > best_s_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= idx_reg;
                            best_s_reg <= ram_rd.s;
                        end
                    end
                    idx_reg <= last_idx ? cls_idx_reg : idx_reg + AW'(1);
                    st_reg <= st_next;
                end
                S_EMIT_RD:
                begin
                    live_reg[best_reg] <= 1'b0;
                    found_reg <= 1'b0;
                    st_reg <= st_next;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        best_e_reg <= ram_rd;
                        // previous kept box is now known not to be last
                        if (pend_reg)
                        begin
                            out_reg <= pend_e_reg;
                        end
                        pend_e_reg <= '{out_left: ram_rd.l, out_top: ram_rd.t,
                                        out_right: ram_rd.r, out_bottom: ram_rd.b,
                                        out_score: ram_rd.s, out_class: ram_rd.c,
                                        last_kept: 1'b0, overflowed: ovf_reg};
                        pend_reg <= 1'b1;
                        idx_reg <= cls_idx_reg;
                        st_reg <= st_next;
                    end
                end
                S_SUP_RD:
                begin
                    st_reg <= st_next;
                end
                S_SUP_CK:
                begin
                    if (!iou_start)
                    begin
                        idx_reg <= last_idx ? cls_idx_reg : idx_reg + AW'(1);
                    end
                    st_reg <= st_next;
                end
                S_SUP_WT:
                begin
                    if (iou.done)
                    begin
                        if (iou.hit)
                        begin
                            live_reg[idx_reg] <= 1'b0;
                        end
                        idx_reg <= last_idx ? cls_idx_reg : idx_reg + AW'(1);
                    end
                    st_reg <= st_next;
                end
                S_NEXT_CLS:
                begin
                    idx_reg <= cls_idx_reg;
                    st_reg <= st_next;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg <= final_out;
                        pend_reg <= 1'b0;
                        count_reg <= '0;
                        ovf_reg <= 1'b0;
                        live_reg <= '0;
                    end
                    st_reg <= st_next;
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
endmodule
